[src/frw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frw_pkg
// Shared types and constants for the device frame rate watchdog.
// ----------------------------------------------------------------------------
package frw_pkg;

    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;
    localparam int GROUP_W   = 5;

    // group flag bit positions
    localparam int GRP_A      = 0;
    localparam int GRP_B      = 1;
    localparam int GRP_C      = 2;
    localparam int GRP_IMU    = 3;
    localparam int GRP_REMOTE = 4;

    // request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_FRAME = 1'b1;

    // register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_LIMIT = 3'd0,
        CFG_SLOW_LIMIT = 3'd1,
        CFG_MOTOR_MIN  = 3'd2,
        CFG_IMU_MIN    = 3'd3,
        CFG_IMU_CLEAR  = 3'd4,
        CFG_REMOTE_MIN = 3'd5
    } t_cfg_idx;

    localparam logic [CNT_W-1:0] RST_FAST_LIMIT = 8'd5;
    localparam logic [CNT_W-1:0] RST_SLOW_LIMIT = 8'd20;
    localparam logic [CNT_W-1:0] RST_MOTOR_MIN  = 8'd5;
    localparam logic [CNT_W-1:0] RST_IMU_MIN    = 8'd4;
    localparam logic [CNT_W-1:0] RST_IMU_CLEAR  = 8'd2;
    localparam logic [CNT_W-1:0] RST_REMOTE_MIN = 8'd5;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    typedef struct packed {
        logic [CNT_W-1:0] fast_limit;
        logic [CNT_W-1:0] slow_limit;
        logic [CNT_W-1:0] motor_min;
        logic [CNT_W-1:0] imu_min;
        logic [CNT_W-1:0] imu_clear;
        logic [CNT_W-1:0] remote_min;
    } t_cfg;

endpackage

[src/frw_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frw_cfg_regs
// Window limits and frame thresholds, written through a plain write port.
// ----------------------------------------------------------------------------
module frw_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [frw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [frw_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    output frw_pkg::t_cfg                  o_cfg
);

    frw_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_limit <= frw_pkg::RST_FAST_LIMIT;
            r_cfg.slow_limit <= frw_pkg::RST_SLOW_LIMIT;
            r_cfg.motor_min  <= frw_pkg::RST_MOTOR_MIN;
            r_cfg.imu_min    <= frw_pkg::RST_IMU_MIN;
            r_cfg.imu_clear  <= frw_pkg::RST_IMU_CLEAR;
            r_cfg.remote_min <= frw_pkg::RST_REMOTE_MIN;
        end else if (i_cfg_we) begin
            unique case (frw_pkg::t_cfg_idx'(i_cfg_index))
                frw_pkg::CFG_FAST_LIMIT: r_cfg.fast_limit <= i_cfg_data;
                frw_pkg::CFG_SLOW_LIMIT: r_cfg.slow_limit <= i_cfg_data;
                frw_pkg::CFG_MOTOR_MIN:  r_cfg.motor_min  <= i_cfg_data;
                frw_pkg::CFG_IMU_MIN:    r_cfg.imu_min    <= i_cfg_data;
                frw_pkg::CFG_IMU_CLEAR:  r_cfg.imu_clear  <= i_cfg_data;
                frw_pkg::CFG_REMOTE_MIN: r_cfg.remote_min <= i_cfg_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/frw_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frw_core
// Per-device frame counters, window tick counters and offline flags.
// ----------------------------------------------------------------------------
module frw_core #(
    parameter int GROUP_A_SIZE = 5,
    parameter int GROUP_B_SIZE = 3,
    parameter int GROUP_C_SIZE = 3,
    localparam int NUM_MOT = GROUP_A_SIZE + GROUP_B_SIZE + GROUP_C_SIZE,
    localparam int NUM_DEV = NUM_MOT + 2,
    localparam int DEV_W   = $clog2(NUM_DEV)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_req,
    input  logic [DEV_W-1:0]              i_dev,
    input  frw_pkg::t_cfg                 i_cfg,
    output logic [NUM_DEV-1:0]            o_flags,
    output logic [frw_pkg::GROUP_W-1:0]   o_groups
);

    localparam int IMU_IDX = NUM_MOT;
    localparam int REM_IDX = NUM_MOT + 1;
    localparam int B_LO    = GROUP_A_SIZE;
    localparam int C_LO    = GROUP_A_SIZE + GROUP_B_SIZE;

    logic [frw_pkg::CNT_W-1:0] r_fast;
    logic [frw_pkg::CNT_W-1:0] r_slow;
    logic [frw_pkg::CNT_W-1:0] r_counts [NUM_DEV];
    logic [NUM_DEV-1:0]        r_flags;

    logic [frw_pkg::CNT_W-1:0] n_fast;
    logic [frw_pkg::CNT_W-1:0] n_slow;
    logic [frw_pkg::CNT_W-1:0] n_counts [NUM_DEV];
    logic [NUM_DEV-1:0]        n_flags;

    logic [frw_pkg::CNT_W-1:0] fast_inc;
    logic [frw_pkg::CNT_W-1:0] slow_inc;
    logic                      is_tick;
    logic                      fast_end;
    logic                      slow_end;

    always_comb begin
        is_tick  = (i_req == frw_pkg::REQ_TICK);
        fast_inc = r_fast + 8'd1;
        slow_inc = r_slow + 8'd1;
        fast_end = is_tick && (fast_inc > i_cfg.fast_limit);
        slow_end = is_tick && (slow_inc > i_cfg.slow_limit);

        n_fast = r_fast;
        n_slow = r_slow;
        if (is_tick) begin
            n_fast = fast_end ? '0 : fast_inc;
            n_slow = slow_end ? '0 : slow_inc;
        end

        n_flags = r_flags;
        for (int i = 0; i < NUM_DEV; i++) begin
            n_counts[i] = r_counts[i];
            // frame arrival; out-of-range indexes match no lane
            if (!is_tick && i_dev == DEV_W'(i) && r_counts[i] != frw_pkg::CNT_MAX) begin
                n_counts[i] = r_counts[i] + 8'd1;
            end
            if (i < NUM_MOT && fast_end) begin
                n_flags[i]  = (r_counts[i] < i_cfg.motor_min);
                n_counts[i] = '0;
            end
        end

        if (slow_end) begin
            n_flags[IMU_IDX] = (r_counts[IMU_IDX] < i_cfg.imu_min);
            if (r_counts[IMU_IDX] > i_cfg.imu_clear) begin
                n_counts[IMU_IDX] = '0;
            end
            n_flags[REM_IDX]  = (r_counts[REM_IDX] < i_cfg.remote_min);
            n_counts[REM_IDX] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast  <= '0;
            r_slow  <= '0;
            r_flags <= '0;
            for (int i = 0; i < NUM_DEV; i++) begin
                r_counts[i] <= '0;
            end
        end else if (i_fire) begin
            r_fast  <= n_fast;
            r_slow  <= n_slow;
            r_flags <= n_flags;
            for (int i = 0; i < NUM_DEV; i++) begin
                r_counts[i] <= n_counts[i];
            end
        end
    end

    assign o_flags = n_flags;

    always_comb begin
        o_groups                      = '0;
        o_groups[frw_pkg::GRP_A]      = |n_flags[GROUP_A_SIZE-1:0];
        o_groups[frw_pkg::GRP_B]      = |n_flags[C_LO-1:B_LO];
        o_groups[frw_pkg::GRP_C]      = |n_flags[NUM_MOT-1:C_LO];
        o_groups[frw_pkg::GRP_IMU]    = n_flags[IMU_IDX];
        o_groups[frw_pkg::GRP_REMOTE] = n_flags[REM_IDX];
    end

    // a frame never changes the offline flags
    a_frame_keeps_flags: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req == frw_pkg::REQ_FRAME) |=> $stable(r_flags)
    ) else $error("offline flags changed on a frame transfer");

    // end of fast window clears motor counters
    a_fast_end_clears: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && fast_end) |=> (r_counts[0] == '0 && r_fast == '0)
    ) else $error("motor count not cleared at fast window end");

    // window counters only move on a transfer
    a_counters_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_fast) && $stable(r_slow))
    ) else $error("window counter moved without a transfer");

endmodule

[src/device_frame_rate_watchdog.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_frame_rate_watchdog
// Liveness monitor: counts frames per device over fast and slow tick windows
// and reports per-device and per-group offline flags after every transfer.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------
//  in       | input     | i_in_valid / o_in_stall   | i_req_type, i_device_index
//  out      | output    | o_out_valid / i_out_stall | o_device_offline,
//           |           |                           | o_group_offline
//  cfg      | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  One item per clock sustained while the result is not stalled; an input
//  goes into the input register, then the state update lands in the result
//  register. Reset clears all counters and the offline flags in the core and
//  reloads the register defaults.
//  A stalled result holds the input register; o_in_stall rises only when the
//  input register is full and a full result register is stalled.
// ----------------------------------------------------------------------------
module device_frame_rate_watchdog #(
    parameter int GROUP_A_SIZE = 5,
    parameter int GROUP_B_SIZE = 3,
    parameter int GROUP_C_SIZE = 3,
    localparam int NUM_DEV = GROUP_A_SIZE + GROUP_B_SIZE + GROUP_C_SIZE + 2,
    localparam int DEV_W   = $clog2(NUM_DEV)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [DEV_W-1:0]              i_device_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [NUM_DEV-1:0]            o_device_offline,
    output logic [frw_pkg::GROUP_W-1:0]   o_group_offline,
    input  logic                          i_cfg_we,
    input  logic [frw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [frw_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    frw_pkg::t_cfg cfg;

    logic                        r_in_valid;
    logic                        r_in_req;
    logic [DEV_W-1:0]            r_in_dev;
    logic                        r_out_valid;
    logic [NUM_DEV-1:0]          r_out_flags;
    logic [frw_pkg::GROUP_W-1:0] r_out_groups;

    logic                        out_free;
    logic                        fire;
    logic                        in_accept;
    logic [NUM_DEV-1:0]          n_flags;
    logic [frw_pkg::GROUP_W-1:0] n_groups;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    frw_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    frw_core #(
        .GROUP_A_SIZE (GROUP_A_SIZE),
        .GROUP_B_SIZE (GROUP_B_SIZE),
        .GROUP_C_SIZE (GROUP_C_SIZE)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_req    (r_in_req),
        .i_dev    (r_in_dev),
        .i_cfg    (cfg),
        .o_flags  (n_flags),
        .o_groups (n_groups)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_req <= i_req_type;
            r_in_dev <= i_device_index;
        end
        if (fire) begin
            r_out_flags  <= n_flags;
            r_out_groups <= n_groups;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_device_offline = r_out_flags;
    assign o_group_offline  = r_out_groups;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the device frame rate watchdog. A scoreboard
// class predicts the offline flags for every input transfer and checks each
// result transfer against the oldest prediction. Covers reset settings,
// directed device and window cases, count saturation, window counter wrap,
// and random traffic under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb;

    localparam int N_A        = 5;
    localparam int N_B        = 3;
    localparam int N_C        = 3;
    localparam int N_MOTOR    = N_A + N_B + N_C;
    localparam int IMU_IDX    = N_MOTOR;
    localparam int REMOTE_IDX = N_MOTOR + 1;
    localparam int N_DEV      = N_MOTOR + 2;
    localparam int IDX_W      = 4;
    localparam int STALL_LIMIT = 2000;

    // index with no register behind it; writes must be ignored
    localparam logic [frw_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    typedef struct packed {
        logic [N_DEV-1:0]            dev_off;
        logic [frw_pkg::GROUP_W-1:0] grp_off;
    } t_watch_status;

    class t_liveness_scoreboard;
        logic [frw_pkg::CNT_W-1:0] fast_lim, slow_lim, motor_min;
        logic [frw_pkg::CNT_W-1:0] imu_min, imu_clr, remote_min;
        logic [frw_pkg::CNT_W-1:0] fast_ticks, slow_ticks;
        logic [frw_pkg::CNT_W-1:0] frames [N_DEV];
        logic [N_DEV-1:0]          offline;
        t_watch_status             due_q [$];
        int                        n_errors;
        int                        n_in;
        int                        n_out;

        function new();
            fast_lim   = frw_pkg::RST_FAST_LIMIT;
            slow_lim   = frw_pkg::RST_SLOW_LIMIT;
            motor_min  = frw_pkg::RST_MOTOR_MIN;
            imu_min    = frw_pkg::RST_IMU_MIN;
            imu_clr    = frw_pkg::RST_IMU_CLEAR;
            remote_min = frw_pkg::RST_REMOTE_MIN;
            fast_ticks = '0;
            slow_ticks = '0;
            foreach (frames[i]) frames[i] = '0;
            offline  = '0;
            n_errors = 0;
            n_in     = 0;
            n_out    = 0;
        endfunction

        function void write_reg(logic [frw_pkg::CFG_IDX_W-1:0] idx,
                                logic [frw_pkg::CFG_DAT_W-1:0] val);
            case (idx)
                frw_pkg::CFG_FAST_LIMIT: fast_lim   = val;
                frw_pkg::CFG_SLOW_LIMIT: slow_lim   = val;
                frw_pkg::CFG_MOTOR_MIN:  motor_min  = val;
                frw_pkg::CFG_IMU_MIN:    imu_min    = val;
                frw_pkg::CFG_IMU_CLEAR:  imu_clr    = val;
                frw_pkg::CFG_REMOTE_MIN: remote_min = val;
                default: ;
            endcase
        endfunction

        function void note_transfer(logic req, logic [IDX_W-1:0] dev);
            t_watch_status s;
            n_in++;
            if (req == frw_pkg::REQ_FRAME) begin
                if (dev < N_DEV && frames[dev] != frw_pkg::CNT_MAX)
                    frames[dev] = frames[dev] + 1'b1;
            end else begin
                fast_ticks = fast_ticks + 1'b1;
                slow_ticks = slow_ticks + 1'b1;
                if (fast_ticks > fast_lim) begin
                    for (int i = 0; i < N_MOTOR; i++) begin
                        offline[i] = frames[i] < motor_min;
                        frames[i]  = '0;
                    end
                    fast_ticks = '0;
                end
                // fast check runs first when both windows close together
                if (slow_ticks > slow_lim) begin
                    offline[IMU_IDX] = frames[IMU_IDX] < imu_min;
                    if (frames[IMU_IDX] > imu_clr)
                        frames[IMU_IDX] = '0;
                    offline[REMOTE_IDX] = frames[REMOTE_IDX] < remote_min;
                    frames[REMOTE_IDX]  = '0;
                    slow_ticks = '0;
                end
            end
            s.dev_off = offline;
            s.grp_off = '0;
            s.grp_off[frw_pkg::GRP_A]      = |offline[N_A-1:0];
            s.grp_off[frw_pkg::GRP_B]      = |offline[N_A+N_B-1:N_A];
            s.grp_off[frw_pkg::GRP_C]      = |offline[N_MOTOR-1:N_A+N_B];
            s.grp_off[frw_pkg::GRP_IMU]    = offline[IMU_IDX];
            s.grp_off[frw_pkg::GRP_REMOTE] = offline[REMOTE_IDX];
            due_q.push_back(s);
        endfunction

        task check_result(logic [N_DEV-1:0] dev_off, logic [frw_pkg::GROUP_W-1:0] grp_off);
            t_watch_status want;
            n_out++;
            if (due_q.size() == 0) begin
                report_mismatch("result with nothing expected", 32'(dev_off), 32'd0);
                return;
            end
            want = due_q.pop_front();
            if (dev_off !== want.dev_off)
                report_mismatch("device_offline", 32'(dev_off), 32'(want.dev_off));
            if (grp_off !== want.grp_off)
                report_mismatch("group_offline", 32'(grp_off), 32'(want.grp_off));
        endtask

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s at result %0d: got %0h, expected %0h (t=%0t)",
                     what, n_out, got, want, $realtime);
            n_errors++;
        endtask

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_req_type;
    logic [IDX_W-1:0]              i_device_index;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [N_DEV-1:0]              o_device_offline;
    logic [frw_pkg::GROUP_W-1:0]   o_group_offline;
    logic                          i_cfg_we;
    logic [frw_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [frw_pkg::CFG_DAT_W-1:0] i_cfg_data;

    t_liveness_scoreboard sb;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_left;
    int quiet_cycles;

    device_frame_rate_watchdog #(
        .GROUP_A_SIZE(N_A),
        .GROUP_B_SIZE(N_B),
        .GROUP_C_SIZE(N_C)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_device_index  (i_device_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_device_offline(o_device_offline),
        .o_group_offline (o_group_offline),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // receiver: long hold-off when requested, random stalls otherwise
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // monitors and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                sb.note_transfer(i_req_type, i_device_index);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_device_offline, o_group_offline);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic frw_pkg::t_cfg mk_cfg(int f, int s, int m, int i, int c, int r);
        frw_pkg::t_cfg cfg;
        cfg.fast_limit = frw_pkg::CNT_W'(f);
        cfg.slow_limit = frw_pkg::CNT_W'(s);
        cfg.motor_min  = frw_pkg::CNT_W'(m);
        cfg.imu_min    = frw_pkg::CNT_W'(i);
        cfg.imu_clear  = frw_pkg::CNT_W'(c);
        cfg.remote_min = frw_pkg::CNT_W'(r);
        return cfg;
    endfunction

    task automatic put_reg(input logic [frw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [frw_pkg::CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
    endtask

    task automatic program_regs(input frw_pkg::t_cfg c);
        put_reg(frw_pkg::CFG_FAST_LIMIT, c.fast_limit);
        put_reg(frw_pkg::CFG_SLOW_LIMIT, c.slow_limit);
        put_reg(frw_pkg::CFG_MOTOR_MIN,  c.motor_min);
        put_reg(frw_pkg::CFG_IMU_MIN,    c.imu_min);
        put_reg(frw_pkg::CFG_IMU_CLEAR,  c.imu_clear);
        put_reg(frw_pkg::CFG_REMOTE_MIN, c.remote_min);
        put_reg(CFG_SPARE_IDX,  frw_pkg::CFG_DAT_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // holds the payload until the transfer happens
    task automatic send_item(input logic req, input logic [IDX_W-1:0] dev);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_device_index <= dev;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_tick();
        send_item(frw_pkg::REQ_TICK, IDX_W'($urandom));
    endtask

    // sender pauses until every expected result has come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_random(input int tick_pct);
        logic [IDX_W-1:0] dev;
        if ($urandom_range(99) < 85)
            dev = IDX_W'($urandom_range(REMOTE_IDX));
        else
            dev = IDX_W'($urandom_range(15, N_DEV));
        if ($urandom_range(99) < tick_pct)
            send_item(frw_pkg::REQ_TICK, dev);
        else
            send_item(frw_pkg::REQ_FRAME, dev);
    endtask

    task automatic run_phase(input frw_pkg::t_cfg c, input int n, input int tick_pct,
                             input int tx, input int rx, input int hold);
        drain();
        program_regs(c);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        hold_left    = hold;
        repeat (n) send_random(tick_pct);
    endtask

    initial begin
        int dir_devs [$];
        int hot_dev;
        int ticks_left;
        int hot_left;
        int noise_left;
        int pick;

        sb = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_req_type     = frw_pkg::REQ_TICK;
        i_device_index = '0;
        i_out_stall    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = frw_pkg::CFG_FAST_LIMIT;
        i_cfg_data     = '0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: first fast window closes on the sixth tick
        repeat (7) send_tick();

        // short windows; every group boundary and the unknown indexes
        drain();
        program_regs(mk_cfg(0, 1, 1, 1, 0, 1));
        dir_devs = '{0, 4, 5, 7, 8, 10, 11, 12, 13, 15, 14};
        foreach (dir_devs[k]) send_item(frw_pkg::REQ_FRAME, IDX_W'(dir_devs[k]));
        send_tick();
        send_tick();
        send_item(frw_pkg::REQ_FRAME, IDX_W'(IMU_IDX));
        send_item(frw_pkg::REQ_FRAME, IDX_W'(IMU_IDX));
        send_tick();
        send_tick();

        run_phase(mk_cfg(2, 6, 1, 2, 1, 2), 130, 25, 0, 0, 150);
        run_phase(mk_cfg(0, 0, 0, 0, 0, 0), 130, 30, 60, 0, 0);
        run_phase(mk_cfg(7, 3, 3, 3, 4, 1), 130, 20, 0, 60, 0);
        run_phase(mk_cfg($urandom_range(6), $urandom_range(6), $urandom_range(3),
                         $urandom_range(3), $urandom_range(3), $urandom_range(3)),
                  130, 25, 35, 35, 0);

        // windows never close at limit 255 while counters wrap; one device
        // is hammered past saturation
        drain();
        program_regs(mk_cfg(255, 255, 255, 255, 255, 255));
        hot_dev    = $urandom_range(REMOTE_IDX);
        ticks_left = 258;
        hot_left   = 262;
        noise_left = 20;
        while (ticks_left + hot_left + noise_left > 0) begin
            pick = $urandom_range(ticks_left + hot_left + noise_left - 1);
            if (pick < ticks_left) begin
                send_tick();
                ticks_left--;
            end else if (pick < ticks_left + hot_left) begin
                send_item(frw_pkg::REQ_FRAME, IDX_W'(hot_dev));
                hot_left--;
            end else begin
                send_item(frw_pkg::REQ_FRAME, IDX_W'($urandom));
                noise_left--;
            end
        end

        // close both windows at once against the highest thresholds
        run_phase(mk_cfg(0, 0, 255, 255, 255, 255), 20, 50, 0, 0, 0);
        run_phase(mk_cfg($urandom_range(12), $urandom_range(12), $urandom_range(4),
                         $urandom_range(4), $urandom_range(4), $urandom_range(4)),
                  130, 25, 0, 0, 0);

        drain();
        repeat (10) @(posedge i_clk);
        $display("Run covered %0d input and %0d result transfers over directed, saturation,",
                 sb.n_in, sb.n_out);
        $display("wrap and random register settings with varied idling; %0d mismatches",
                 sb.n_errors);
        if (sb.n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
